@@ src/b32oe_pkg.sv @@
package b32oe_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned SymW    = 5;
    localparam int unsigned AccW    = 12;
    localparam int unsigned HeldW   = 4;
    localparam int unsigned CountW  = 6;

    localparam logic [CountW-1:0] ShortLen = 6'd16;
    localparam logic [CountW-1:0] LongLen  = 6'd56;

    // Letters cover codes 0..25, digits 2..7 cover codes 26..31.
    localparam logic [SymW-1:0] FirstDigitCode = 5'd26;

    typedef logic [ByteW-1:0] char_t;

    function automatic char_t sym_to_ascii(input logic [SymW-1:0] code);
        char_t ch;
        if (code < FirstDigitCode)
        begin
            ch = 8'h61 + {3'b000, code};
        end
        else
        begin
            ch = 8'h32 + {3'b000, code - FirstDigitCode};
        end
        return ch;
    endfunction

endpackage

@@ src/base32_onion_encoder.sv @@
// base32_onion_encoder: lower-case base32 encoder for onion addresses.
//
// Input channel: data_byte with in_valid / in_stall; a beat moves at a rising
// edge with in_valid high and in_stall low. Bytes enter MSB first.
// Output channel: symbol_char and last_symbol with out_valid / out_stall.
// Each byte yields one or two ASCII characters; last_symbol marks the final
// character of a message (16 chars when short_address = 1, else 56).
// Config: short_address is written from cfg_wr_data when cfg_wr_en is high;
// write it only while the block is idle.
// Timing: a byte's first character is in the output register in the cycle
// after the byte is accepted; its second character waits in the hold slot.
// Throughput: with no output stall, one byte per cycle when it gives one
// character; a byte that gives two holds off the next until the hold slot
// empties; output register and hold slot drain one character per cycle.
// Stall: in_stall rises while the hold slot is full, or while the output
// beat is stalled; nothing is dropped or repeated.
// Reset: clears the bit accumulator, counters, mode (long) and both slots.
module base32_onion_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] symbol_char,
    output logic       last_symbol
);
    import b32oe_pkg::*;

    // mode
    logic short_address_reg;

    // encoder state
    logic [AccW-1:0]   acc_reg, acc_next;
    logic [HeldW-1:0]  held_reg, held_next;
    logic [CountW-1:0] count_reg, count_next;

    // output register and hold slot for the second character of a byte
    logic        o_valid_reg, o_valid_next;
    char_t       o_char_reg, o_char_next;
    logic        o_last_reg, o_last_next;
    logic        h_valid_reg, h_valid_next;
    char_t       h_char_reg, h_char_next;
    logic        h_last_reg, h_last_next;

    logic              in_fire, out_fire;
    logic [CountW-1:0] target;
    logic [AccW-1:0]   base_acc, acc_in, acc1, acc2;
    logic [HeldW-1:0]  base_held, h0, h1, h2;
    logic [CountW-1:0] count1, count2;
    logic [SymW-1:0]   idx0, idx1;
    logic              last0, last1, two_chars;

    assign in_stall = h_valid_reg || (o_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = o_valid_reg && !out_stall;
    assign target   = short_address_reg ? ShortLen : LongLen;

    // One byte through the accumulator: up to two 5-bit groups.
    always_comb
    begin
        base_held = (held_reg > 4'd4) ? '0 : held_reg;
        base_acc  = (held_reg > 4'd4) ? '0 : acc_reg;
        acc_in    = {base_acc[AccW-ByteW-1:0], data_byte};
        h0        = base_held + 4'd8;

        h1     = h0 - 4'd5;
        idx0   = SymW'(acc_in >> h1);
        acc1   = acc_in & AccW'((13'd1 << h1) - 13'd1);
        count1 = count_reg + 6'd1;
        last0  = (count1 >= target);

        h2     = h1 - 4'd5;
        idx1   = SymW'(acc1 >> h2);
        acc2   = acc1 & AccW'((13'd1 << h2) - 13'd1);
        count2 = count1 + 6'd1;
        last1  = (count2 >= target);

        two_chars = !last0 && (h1 >= 4'd5);

        acc_next   = acc_reg;
        held_next  = held_reg;
        count_next = count_reg;
        if (in_fire)
        begin
            priority if (last0 || (two_chars && last1))
            begin
                acc_next   = '0;
                held_next  = '0;
                count_next = '0;
            end
            else if (two_chars)
            begin
                acc_next   = acc2;
                held_next  = h2;
                count_next = count2;
            end
            else
            begin
                acc_next   = acc1;
                held_next  = h1;
                count_next = count1;
            end
        end
    end

    // Output register / hold slot steering.
    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_char_next  = o_char_reg;
        o_last_next  = o_last_reg;
        h_valid_next = h_valid_reg;
        h_char_next  = h_char_reg;
        h_last_next  = h_last_reg;
        priority if (h_valid_reg)
        begin
            if (!o_valid_reg || out_fire)
            begin
                o_valid_next = 1'b1;
                o_char_next  = h_char_reg;
                o_last_next  = h_last_reg;
                h_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            o_valid_next = 1'b1;
            o_char_next  = sym_to_ascii(idx0);
            o_last_next  = last0;
            h_valid_next = two_chars;
            h_char_next  = sym_to_ascii(idx1);
            h_last_next  = last1;
        end
        else
        begin
            if (out_fire)
            begin
                o_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_address_reg <= 1'b0;
            acc_reg           <= '0;
            held_reg          <= '0;
            count_reg         <= '0;
            o_valid_reg       <= 1'b0;
            h_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                short_address_reg <= cfg_wr_data;
            end
            acc_reg     <= acc_next;
            held_reg    <= held_next;
            count_reg   <= count_next;
            o_valid_reg <= o_valid_next;
            h_valid_reg <= h_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        o_char_reg <= o_char_next;
        o_last_reg <= o_last_next;
        h_char_reg <= h_char_next;
        h_last_reg <= h_last_next;
    end

    assign out_valid   = o_valid_reg;
    assign symbol_char = o_char_reg;
    assign last_symbol = o_last_reg;

`ifndef SYNTHESIS
    // hold slot only fills behind a full output register
    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        h_valid_reg |-> o_valid_reg)
        else $error("hold slot valid while output register empty");

    // leftover bits never reach a full group
    a_held_small: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= 4'd4)
        else $error("bits held above four");

    // a flagged first character restarts the message
    a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last0) |=> (count_reg == '0 && held_reg == '0 && !h_valid_reg))
        else $error("message did not restart after last character");
`endif

endmodule

@@ dv/base32_onion_encoder_tb.sv @@
`timescale 1ns / 1ps

module base32_onion_encoder_tb;

    import b32oe_pkg::*;

    // Generous ceiling for ~1100 bytes of up to two characters each under heavy
    // stall plus sender gaps.
    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned MaxReports = 100;
    localparam int unsigned RandomPhases = 10;
    localparam int unsigned BytesPerPhase = 110;

    // Mode register values
    localparam logic ModeLong  = 1'b0;
    localparam logic ModeShort = 1'b1;

    typedef struct packed {
        char_t ch;
        logic  last;
    } symbol_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] symbol_char;
    logic       last_symbol;

    base32_onion_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol_char (symbol_char),
        .last_symbol (last_symbol)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Encoder prediction: own copy of the mode and the bit accumulator.
    // ------------------------------------------------------------------
    string       alphabet = "abcdefghijklmnopqrstuvwxyz234567";
    logic        short_mode;
    logic [11:0] pending_bits;
    logic [3:0]  pending_count;
    logic [5:0]  chars_in_msg;

    symbol_t     expected_symbols[$];

    int unsigned error_count;
    int unsigned bytes_sent;
    int unsigned chars_checked;
    int unsigned messages_seen;
    int unsigned open_msg_switches;
    int unsigned cycle_count;
    int unsigned stall_pct;

    // Turns one accepted byte into the one or two characters it must give.
    task automatic encode_byte(input logic [7:0] b);
        logic [5:0] msg_len;
        logic [3:0] shift;
        logic [4:0] code;
        symbol_t    sym;
        int         n;
        msg_len = short_mode ? ShortLen : LongLen;
        // entry invariant: fewer than five bits left over
        if (pending_count > 4'd4)
        begin
            pending_count = '0;
            pending_bits = '0;
        end
        pending_bits = {pending_bits[3:0], b};
        pending_count = pending_count + 4'd8;
        n = 0;
        while (pending_count >= 4'd5 && n < 2)
        begin
            shift = pending_count - 4'd5;
            code = 5'(pending_bits >> shift);
            pending_count = shift;
            pending_bits = pending_bits & ((12'd1 << shift) - 12'd1);
            chars_in_msg = chars_in_msg + 6'd1;
            sym.ch = char_t'(alphabet[code]);
            sym.last = (chars_in_msg >= msg_len);
            expected_symbols.push_back(sym);
            n++;
            // message done: leftover bits of this byte are discarded
            if (sym.last)
            begin
                pending_bits = '0;
                pending_count = '0;
                chars_in_msg = '0;
                break;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, density set per test phase.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_pct == 0)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted output beat against the oldest
    // expected character.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_symbols
        symbol_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            chars_checked++;
            if (last_symbol)
            begin
                messages_seen++;
            end
            if (expected_symbols.size() == 0)
            begin
                error_count++;
                if (error_count <= MaxReports)
                begin
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $time, symbol_char, last_symbol);
                end
            end
            else
            begin
                want = expected_symbols.pop_front();
                if (symbol_char !== want.ch)
                begin
                    error_count++;
                    if (error_count <= MaxReports)
                    begin
                        $display("%0t: symbol_char expected %h actual %h",
                                 $time, want.ch, symbol_char);
                    end
                end
                if (last_symbol !== want.last)
                begin
                    error_count++;
                    if (error_count <= MaxReports)
                    begin
                        $display("%0t: last_symbol expected %b actual %b",
                                 $time, want.last, last_symbol);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("%0t: timeout with %0d characters outstanding",
                     $time, expected_symbols.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared sender: idle for the requested gap, then present one beat and hold
    // it until it is taken. Valid stays high between back-to-back beats.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input int unsigned gap);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            data_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        encode_byte(b);
        bytes_sent++;
    endtask

    // Drop valid and wait until every predicted character has come out,
    // then let the output pipe settle.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_symbols.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        drain();
        if (chars_in_msg != 0 || pending_count != 0)
        begin
            open_msg_switches++;
        end
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        short_mode = mode;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One full 16-character message: all-zero and all-one bytes, single
    // edge bits, alternating patterns.
    task automatic test_short_message;
        logic [7:0] pattern[10];
        pattern = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA};
        stall_pct = 0;
        write_mode(ModeShort);
        foreach (pattern[i])
        begin
            send_byte(pattern[i], 0);
        end
        drain();
    endtask

    // Long mode, stop after 19 characters with one bit pending, then switch
    // to short: the next byte's first character ends the message and the
    // rest of that byte is thrown away.
    task automatic test_mode_switch_open_message;
        stall_pct = 30;
        write_mode(ModeLong);
        for (int i = 0; i < 12; i++)
        begin
            send_byte(8'(8'h11 * i + 8'h0F), (i % 4 == 3) ? 2 : 0);
        end
        write_mode(ModeShort);
        send_byte(8'hC3, 0);
        drain();
    endtask

    // Continuous stream of random bytes in phases. Each phase picks a mode,
    // a stall density and a burst shape; phase boundaries usually land in
    // the middle of a message, so mode changes with a message open recur.
    task automatic test_random_stream;
        int unsigned burst_left;
        int unsigned max_gap;
        int unsigned gap;
        logic        mode;
        for (int unsigned phase = 0; phase < RandomPhases; phase++)
        begin
            mode = (phase % 3 == 2) ? 1'($urandom_range(1)) : phase[0];
            write_mode(mode);
            case (phase % 4)
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
            max_gap = (phase % 5 == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            for (int unsigned k = 0; k < BytesPerPhase; k++)
            begin
                gap = 0;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    if (max_gap != 0)
                    begin
                        gap = $urandom_range(1, max_gap);
                    end
                end
                burst_left--;
                send_byte(8'($urandom_range(255)), gap);
            end
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        short_mode = ModeLong;
        pending_bits = '0;
        pending_count = '0;
        chars_in_msg = '0;
        error_count = 0;
        bytes_sent = 0;
        chars_checked = 0;
        messages_seen = 0;
        open_msg_switches = 0;
        cycle_count = 0;
        stall_pct = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_short_message();
        test_mode_switch_open_message();
        test_random_stream();

        drain();
        if (expected_symbols.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected characters never arrived",
                     $time, expected_symbols.size());
        end

        $display("Encoded %0d bytes into %0d checked characters over %0d messages,",
                 bytes_sent, chars_checked, messages_seen);
        $display("both lengths, %0d mode changes with a message open, %0d errors.",
                 open_msg_switches, error_count);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/b32oe_pkg.sv
src/base32_onion_encoder.sv
dv/base32_onion_encoder_tb.sv
